// ===== src/valrot_pkg.sv =====
package valrot_pkg;

  localparam int COORD_WIDTH = 32;

  localparam int UNIT_FRAC = 30;
  localparam int NORM_BITS = 23;
  localparam int SPLIT_BITS = 24;
  localparam int VEXT_W = 2 * SPLIT_BITS;

  localparam int USUM_W = 2 * NORM_BITS + 2;
  localparam int USQ_RW = USUM_W / 2;
  localparam int UNUM_W = NORM_BITS + UNIT_FRAC + 1;
  localparam int QUO_W = UNIT_FRAC + 1;
  localparam int UNIT_LAT = 4 + USQ_RW + QUO_W + 1;

  localparam int U_W = 32;
  localparam int K2_W = 64;
  localparam int S_W = K2_W / 2;
  localparam int NNUM_W = 2 * UNIT_FRAC + 2;
  localparam int R_W = 35;
  localparam int APPLY_LAT = 3;

  localparam logic [K2_W-1:0] ALIGN_TOL_SQ = 64'd1152922;
  localparam logic signed [R_W-1:0] R_ONE = 35'sd1 <<< UNIT_FRAC;

  typedef enum logic [1:0] {
    STAT_ROTATED = 2'd0,
    STAT_ALIGNED = 2'd1,
    STAT_DEGEN   = 2'd2
  } status_t;

  // Q60 -> Q30, round half away from zero
  function automatic logic signed [35:0] q30(input logic signed [65:0] v);
    logic [65:0] m;
    logic [65:0] r;
    m = v[65] ? 66'(-v) : 66'(v);
    r = (m + (66'd1 << (UNIT_FRAC - 1))) >> UNIT_FRAC;
    return v[65] ? -$signed(r[35:0]) : $signed(r[35:0]);
  endfunction

endpackage

// ===== src/valrot_if.sv =====
interface valrot_in_if #(parameter int CW = valrot_pkg::COORD_WIDTH);
  logic valid;
  logic ready;
  logic signed [CW-1:0] from_x, from_y, from_z;
  logic signed [CW-1:0] to_x, to_y, to_z;
  logic signed [CW-1:0] vec_x, vec_y, vec_z;

  modport source (output valid, from_x, from_y, from_z, to_x, to_y, to_z,
                  vec_x, vec_y, vec_z, input ready);
  modport sink (input valid, from_x, from_y, from_z, to_x, to_y, to_z,
                vec_x, vec_y, vec_z, output ready);
endinterface

interface valrot_out_if #(parameter int CW = valrot_pkg::COORD_WIDTH);
  logic valid;
  logic ready;
  logic signed [CW-1:0] out_x, out_y, out_z;
  logic [1:0] status;

  modport source (output valid, out_x, out_y, out_z, status, input ready);
  modport sink (input valid, out_x, out_y, out_z, status, output ready);
endinterface

// ===== src/valrot_delay.sv =====
module valrot_delay #(
  parameter int W = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sh_r [DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) sh_r[i] <= '0;
    end else if (en) begin
      sh_r[0] <= d;
      for (int i = 1; i < DEPTH; i++) sh_r[i] <= sh_r[i-1];
    end
  end

  assign q = sh_r[DEPTH-1];

endmodule

// ===== src/valrot_isqrt.sv =====
// one root bit per stage
module valrot_isqrt #(
  parameter int XW = 64
) (
  input  logic            clk,
  input  logic            en,
  input  logic [XW-1:0]   x,
  output logic [XW/2-1:0] root
);

  localparam int RW = XW / 2;
  localparam int RMW = RW + 2;

  logic [RMW-1:0] rem_r [RW];
  logic [RW-1:0] root_r [RW];
  logic [XW-1:0] x_r [RW];

  for (genvar g = 0; g < RW; g++) begin : g_stage
    logic [RMW-1:0] rem_in;
    logic [RW-1:0] root_in;
    logic [XW-1:0] x_in;
    logic [RMW+1:0] r2, trial;
    logic ge;

    if (g == 0) begin : g_first
      assign rem_in = '0;
      assign root_in = '0;
      assign x_in = x;
    end else begin : g_next
      assign rem_in = rem_r[g-1];
      assign root_in = root_r[g-1];
      assign x_in = x_r[g-1];
    end

    assign r2 = {rem_in, x_in[XW-1 -: 2]};
    assign trial = {2'b00, root_in, 2'b01};
    assign ge = r2 >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g] <= ge ? RMW'(r2 - trial) : RMW'(r2);
        root_r[g] <= {root_in[RW-2:0], ge};
        x_r[g] <= {x_in[XW-3:0], 2'b00};
      end
    end
  end

  assign root = root_r[RW-1];

endmodule

// ===== src/valrot_div.sv =====
// restoring divider, one quotient bit per stage; quotient must fit QW bits
module valrot_div #(
  parameter int NW = 62,
  parameter int DW = 32,
  parameter int QW = 31
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  logic [DW-1:0] rem_r [QW];
  logic [DW-1:0] den_r [QW];
  logic [QW-1:0] lo_r [QW];
  logic [QW-1:0] q_r [QW];

  for (genvar g = 0; g < QW; g++) begin : g_stage
    logic [DW-1:0] rem_in, den_in;
    logic [QW-1:0] lo_in, q_in;
    logic [DW:0] r2;
    logic ge;

    if (g == 0) begin : g_first
      assign rem_in = DW'(num[NW-1:QW]);
      assign den_in = den;
      assign lo_in = num[QW-1:0];
      assign q_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[g-1];
      assign den_in = den_r[g-1];
      assign lo_in = lo_r[g-1];
      assign q_in = q_r[g-1];
    end

    assign r2 = {rem_in, lo_in[QW-1]};
    assign ge = r2 >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g] <= ge ? DW'(r2 - {1'b0, den_in}) : DW'(r2);
        den_r[g] <= den_in;
        lo_r[g] <= {lo_in[QW-2:0], 1'b0};
        q_r[g] <= {q_in[QW-2:0], ge};
      end
    end
  end

  assign quo = q_r[QW-1];

endmodule

// ===== src/valrot_unit.sv =====
// direction -> Q30 unit vector
module valrot_unit #(
  parameter int CW = valrot_pkg::COORD_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic signed [CW-1:0]             x [3],
  output logic signed [valrot_pkg::U_W-1:0] u [3],
  output logic                             zero
);

  localparam int NB = valrot_pkg::NORM_BITS;
  localparam int PW = (CW > 1) ? $clog2(CW) : 1;
  localparam int SAW = $clog2(CW + 1);
  localparam int QW = valrot_pkg::QUO_W;
  localparam int SQW = valrot_pkg::USQ_RW;
  localparam int NUMW = valrot_pkg::UNUM_W;

  logic [CW-1:0] mag_r [3];
  logic [CW-1:0] max_r;
  logic [2:0] sgn1_r, sgn2_r, sgn3_r, sgn4_r;
  logic [NB-1:0] a2_r [3], a3_r [3], a4_r [3];
  logic zero2_r, zero3_r, zero4_r;
  logic [2*NB-1:0] sq_r [3];
  logic [valrot_pkg::USUM_W-1:0] sum_r;
  logic signed [valrot_pkg::U_W-1:0] u_r [3];
  logic zero_r;

  logic [CW-1:0] mag_nxt [3];
  logic [CW-1:0] m01;
  logic [PW-1:0] pos;
  logic [SAW-1:0] shamt;
  logic [SQW-1:0] root;
  logic [3*NB-1:0] a_d;
  logic [3:0] sz_d;
  logic [QW-1:0] quo [3];

  always_comb begin
    for (int i = 0; i < 3; i++) mag_nxt[i] = x[i][CW-1] ? CW'(-x[i]) : CW'(x[i]);
    m01 = (mag_nxt[0] > mag_nxt[1]) ? mag_nxt[0] : mag_nxt[1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) mag_r[i] <= mag_nxt[i];
      max_r <= (m01 > mag_nxt[2]) ? m01 : mag_nxt[2];
      sgn1_r <= {x[2][CW-1], x[1][CW-1], x[0][CW-1]};
    end
  end

  // msb of the max lands on bit NB-1
  always_comb begin
    pos = '0;
    for (int i = 0; i < CW; i++) begin
      if (max_r[i]) pos = PW'(i);
    end
    shamt = SAW'(pos) + SAW'(1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) a2_r[i] <= NB'({mag_r[i], {NB{1'b0}}} >> shamt);
      zero2_r <= (max_r == '0);
      sgn2_r <= sgn1_r;
      for (int i = 0; i < 3; i++) sq_r[i] <= a2_r[i] * a2_r[i];
      a3_r <= a2_r;
      zero3_r <= zero2_r;
      sgn3_r <= sgn2_r;
      sum_r <= valrot_pkg::USUM_W'(sq_r[0]) + valrot_pkg::USUM_W'(sq_r[1])
             + valrot_pkg::USUM_W'(sq_r[2]);
      a4_r <= a3_r;
      zero4_r <= zero3_r;
      sgn4_r <= sgn3_r;
    end
  end

  valrot_isqrt #(.XW(valrot_pkg::USUM_W)) u_isqrt (
    .clk(clk), .en(en), .x(sum_r), .root(root)
  );

  valrot_delay #(.W(3*NB), .DEPTH(SQW)) u_dly_a (
    .clk(clk), .rst_n(rst_n), .en(en), .d({a4_r[2], a4_r[1], a4_r[0]}), .q(a_d)
  );

  valrot_delay #(.W(4), .DEPTH(SQW + QW)) u_dly_sz (
    .clk(clk), .rst_n(rst_n), .en(en), .d({zero4_r, sgn4_r}), .q(sz_d)
  );

  for (genvar g = 0; g < 3; g++) begin : g_div
    logic [NUMW-1:0] num;
    assign num = (NUMW'(a_d[g*NB +: NB]) << valrot_pkg::UNIT_FRAC) + NUMW'(root >> 1);
    valrot_div #(.NW(NUMW), .DW(SQW), .QW(QW)) u_div (
      .clk(clk), .en(en), .num(num), .den(root), .quo(quo[g])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        u_r[i] <= sz_d[i] ? -$signed({1'b0, quo[i]}) : $signed({1'b0, quo[i]});
      end
      zero_r <= sz_d[3];
    end
  end

  assign u = u_r;
  assign zero = zero_r;

endmodule

// ===== src/valrot_apply.sv =====
// R * v with exact rounding, then saturation
module valrot_apply #(
  parameter int CW = valrot_pkg::COORD_WIDTH
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [valrot_pkg::R_W-1:0] r [3][3],
  input  logic signed [CW-1:0]             v [3],
  output logic signed [CW-1:0]             y [3]
);

  localparam int RW = valrot_pkg::R_W;
  localparam int SB = valrot_pkg::SPLIT_BITS;
  localparam int VW = valrot_pkg::VEXT_W;
  localparam int PLW = RW + SB + 1;
  localparam int PHW = RW + VW - SB;
  localparam int SLW = PLW + 2;
  localparam int SHW = PHW + 2;
  localparam int TW = SHW + SB + 3;
  localparam int OW = TW - valrot_pkg::UNIT_FRAC;

  logic signed [PLW-1:0] pl_r [3][3];
  logic signed [PHW-1:0] ph_r [3][3];
  logic signed [SLW-1:0] sl_r [3];
  logic signed [SHW-1:0] sh_r [3];
  logic signed [CW-1:0] y_r [3];

  logic signed [VW-1:0] ve [3];
  logic signed [SB:0] vl [3];
  logic signed [VW-SB-1:0] vh [3];
  logic signed [TW-1:0] tot [3];
  logic signed [OW-1:0] res [3];
  logic [OW-CW:0] top [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      ve[j] = VW'(v[j]);
      vl[j] = $signed({1'b0, ve[j][SB-1:0]});
      vh[j] = $signed(ve[j][VW-1:SB]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          pl_r[i][j] <= r[i][j] * vl[j];
          ph_r[i][j] <= r[i][j] * vh[j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sl_r[i] <= SLW'(pl_r[i][0]) + SLW'(pl_r[i][1]) + SLW'(pl_r[i][2]);
        sh_r[i] <= SHW'(ph_r[i][0]) + SHW'(ph_r[i][1]) + SHW'(ph_r[i][2]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tot[i] = (TW'(sh_r[i]) <<< SB) + TW'(sl_r[i])
             + (TW'(1) <<< (valrot_pkg::UNIT_FRAC - 1));
      res[i] = tot[i][TW-1:valrot_pkg::UNIT_FRAC];
      top[i] = res[i][OW-1:CW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if ((&top[i]) || !(|top[i])) begin
          y_r[i] <= res[i][CW-1:0];
        end else if (res[i][OW-1]) begin
          y_r[i] <= $signed({1'b1, {(CW-1){1'b0}}});
        end else begin
          y_r[i] <= $signed({1'b0, {(CW-1){1'b1}}});
        end
      end
    end
  end

  assign y = y_r;

endmodule

// ===== src/vector_align_rotation.sv =====
// Throughput: one transaction per cycle when not stalled; the square-root and
// divider units are fully pipelined, one result bit per stage, and set the depth.
// A stall on the output freezes the whole pipeline; nothing is dropped or repeated.
// Reset (synchronous, rst_n low) clears all valid bits; no clearing pass is needed.
module vector_align_rotation #(
  parameter int COORD_WIDTH = valrot_pkg::COORD_WIDTH
) (
  input  logic                clk,
  input  logic                rst_n,
  valrot_in_if.sink           in_if,
  valrot_out_if.source        out_if
);

  localparam int CW = COORD_WIDTH;
  localparam int UW = valrot_pkg::U_W;
  localparam int QW = valrot_pkg::QUO_W;
  localparam int SW = valrot_pkg::S_W;
  localparam int NW = valrot_pkg::NNUM_W;
  localparam int RW = valrot_pkg::R_W;
  localparam int D_V1 = valrot_pkg::UNIT_LAT + 5 + SW + QW + 1 + 4;
  localparam int D_STAT = SW + QW + 1 + 4 + valrot_pkg::APPLY_LAT;
  localparam int D_KC = SW + QW + 2;
  localparam logic signed [32:0] R_ONE_33 = 33'sd1 <<< valrot_pkg::UNIT_FRAC;

  logic en;
  logic signed [CW-1:0] fx [3], tx [3], vx [3];
  logic signed [UW-1:0] f [3], t [3];
  logic zf, zt, zero_d;

  logic signed [63:0] dp_r [3];
  logic signed [63:0] cp_r [6];
  logic signed [65:0] dot_r;
  logic signed [65:0] cr_r [3];
  logic signed [35:0] cq;
  logic signed [31:0] c_r, c4_r, c5_r;
  logic signed [31:0] k_r [3], k4_r [3], k5_r [3];
  logic [63:0] kq_r [3];
  logic [31:0] km [3];
  logic [valrot_pkg::K2_W-1:0] k2_r;
  valrot_pkg::status_t status5;

  logic [SW-1:0] s;
  logic [3*32-1:0] kd;
  logic [2:0] ksgn_d;
  logic [QW-1:0] nq [3];
  logic signed [31:0] n_r [3];
  logic signed [63:0] pp_r [6];
  logic [4*32-1:0] kc_d;
  logic signed [31:0] p_r [6];
  logic signed [32:0] b_r;
  logic signed [31:0] k8_r [3], k9_r [3];
  logic signed [65:0] m_r [6];
  logic signed [RW-1:0] rq [6];
  logic signed [RW-1:0] r_r [3][3];

  logic [3*CW:0] v1_d, v2_d;
  logic [1:0] stat_d;
  logic signed [CW-1:0] v133 [3], v136 [3], y [3];

  logic out_valid_r;
  logic signed [CW-1:0] out_x_r, out_y_r, out_z_r;
  logic [1:0] out_status_r;

  assign en = !out_valid_r || out_if.ready;
  assign in_if.ready = en;

  assign fx = '{in_if.from_x, in_if.from_y, in_if.from_z};
  assign tx = '{in_if.to_x, in_if.to_y, in_if.to_z};
  assign vx = '{in_if.vec_x, in_if.vec_y, in_if.vec_z};

  valrot_unit #(.CW(CW)) u_unit_from (
    .clk(clk), .rst_n(rst_n), .en(en), .x(fx), .u(f), .zero(zf)
  );
  valrot_unit #(.CW(CW)) u_unit_to (
    .clk(clk), .rst_n(rst_n), .en(en), .x(tx), .u(t), .zero(zt)
  );

  // dot and cross products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) dp_r[i] <= f[i] * t[i];
      cp_r[0] <= f[1] * t[2];
      cp_r[1] <= f[2] * t[1];
      cp_r[2] <= f[2] * t[0];
      cp_r[3] <= f[0] * t[2];
      cp_r[4] <= f[0] * t[1];
      cp_r[5] <= f[1] * t[0];
      dot_r <= 66'(dp_r[0]) + 66'(dp_r[1]) + 66'(dp_r[2]);
      for (int i = 0; i < 3; i++) cr_r[i] <= 66'(cp_r[2*i]) - 66'(cp_r[2*i+1]);
    end
  end

  assign cq = valrot_pkg::q30(dot_r);

  always_ff @(posedge clk) begin
    if (en) begin
      if (cq > 36'sd1073741824) begin
        c_r <= 32'sd1073741824;
      end else if (cq < -36'sd1073741824) begin
        c_r <= -32'sd1073741824;
      end else begin
        c_r <= cq[31:0];
      end
      for (int i = 0; i < 3; i++) k_r[i] <= 32'(valrot_pkg::q30(cr_r[i]));
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) km[i] = k_r[i][31] ? 32'(-k_r[i]) : 32'(k_r[i]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) kq_r[i] <= km[i] * km[i];
      k4_r <= k_r;
      c4_r <= c_r;
      k2_r <= kq_r[0] + kq_r[1] + kq_r[2];
      k5_r <= k4_r;
      c5_r <= c4_r;
    end
  end

  valrot_delay #(.W(1), .DEPTH(5)) u_dly_zero (
    .clk(clk), .rst_n(rst_n), .en(en), .d(zf | zt), .q(zero_d)
  );

  always_comb begin
    if (zero_d) begin
      status5 = valrot_pkg::STAT_DEGEN;
    end else if (k2_r < valrot_pkg::ALIGN_TOL_SQ) begin
      status5 = c5_r[31] ? valrot_pkg::STAT_DEGEN : valrot_pkg::STAT_ALIGNED;
    end else begin
      status5 = valrot_pkg::STAT_ROTATED;
    end
  end

  valrot_delay #(.W(2), .DEPTH(D_STAT)) u_dly_stat (
    .clk(clk), .rst_n(rst_n), .en(en), .d(status5), .q(stat_d)
  );

  // unit axis
  valrot_isqrt #(.XW(valrot_pkg::K2_W)) u_isqrt (
    .clk(clk), .en(en), .x(k2_r), .root(s)
  );

  valrot_delay #(.W(3*32), .DEPTH(SW)) u_dly_k (
    .clk(clk), .rst_n(rst_n), .en(en), .d({k5_r[2], k5_r[1], k5_r[0]}), .q(kd)
  );

  valrot_delay #(.W(3), .DEPTH(SW + QW)) u_dly_ksgn (
    .clk(clk), .rst_n(rst_n), .en(en),
    .d({k5_r[2][31], k5_r[1][31], k5_r[0][31]}), .q(ksgn_d)
  );

  for (genvar g = 0; g < 3; g++) begin : g_ndiv
    logic signed [31:0] kk;
    logic [31:0] kmag;
    logic [NW-1:0] num;
    assign kk = kd[g*32 +: 32];
    assign kmag = kk[31] ? 32'(-kk) : 32'(kk);
    assign num = (NW'(kmag) << valrot_pkg::UNIT_FRAC) + NW'(s >> 1);
    valrot_div #(.NW(NW), .DW(SW), .QW(QW)) u_div (
      .clk(clk), .en(en), .num(num), .den(s), .quo(nq[g])
    );
  end

  valrot_delay #(.W(4*32), .DEPTH(D_KC)) u_dly_kc (
    .clk(clk), .rst_n(rst_n), .en(en), .d({c5_r, k5_r[2], k5_r[1], k5_r[0]}), .q(kc_d)
  );

  // rotation matrix
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        n_r[i] <= ksgn_d[i] ? -$signed({1'b0, nq[i]}) : $signed({1'b0, nq[i]});
      end
      pp_r[0] <= n_r[0] * n_r[0];
      pp_r[1] <= n_r[1] * n_r[1];
      pp_r[2] <= n_r[2] * n_r[2];
      pp_r[3] <= n_r[0] * n_r[1];
      pp_r[4] <= n_r[0] * n_r[2];
      pp_r[5] <= n_r[1] * n_r[2];
      for (int i = 0; i < 6; i++) p_r[i] <= 32'(valrot_pkg::q30(66'(pp_r[i])));
      b_r <= 33'(R_ONE_33) - 33'($signed(kc_d[127:96]));
      for (int i = 0; i < 3; i++) k8_r[i] <= $signed(kc_d[i*32 +: 32]);
      m_r[0] <= b_r * (33'(p_r[1]) + 33'(p_r[2]));
      m_r[1] <= b_r * (33'(p_r[2]) + 33'(p_r[0]));
      m_r[2] <= b_r * (33'(p_r[1]) + 33'(p_r[0]));
      m_r[3] <= b_r * 33'(p_r[3]);
      m_r[4] <= b_r * 33'(p_r[4]);
      m_r[5] <= b_r * 33'(p_r[5]);
      k9_r <= k8_r;
    end
  end

  always_comb begin
    for (int i = 0; i < 6; i++) rq[i] = RW'(valrot_pkg::q30(m_r[i]));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_r[0][0] <= valrot_pkg::R_ONE - rq[0];
      r_r[1][1] <= valrot_pkg::R_ONE - rq[1];
      r_r[2][2] <= valrot_pkg::R_ONE - rq[2];
      r_r[0][1] <= rq[3] - RW'(k9_r[2]);
      r_r[1][0] <= rq[3] + RW'(k9_r[2]);
      r_r[0][2] <= rq[4] + RW'(k9_r[1]);
      r_r[2][0] <= rq[4] - RW'(k9_r[1]);
      r_r[1][2] <= rq[5] - RW'(k9_r[0]);
      r_r[2][1] <= rq[5] + RW'(k9_r[0]);
    end
  end

  // pass-through vector and valid
  valrot_delay #(.W(3*CW+1), .DEPTH(D_V1)) u_dly_v1 (
    .clk(clk), .rst_n(rst_n), .en(en),
    .d({in_if.valid, vx[2], vx[1], vx[0]}), .q(v1_d)
  );

  valrot_delay #(.W(3*CW+1), .DEPTH(valrot_pkg::APPLY_LAT)) u_dly_v2 (
    .clk(clk), .rst_n(rst_n), .en(en), .d(v1_d), .q(v2_d)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      v133[i] = $signed(v1_d[i*CW +: CW]);
      v136[i] = $signed(v2_d[i*CW +: CW]);
    end
  end

  valrot_apply #(.CW(CW)) u_apply (
    .clk(clk), .en(en), .r(r_r), .v(v133), .y(y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v2_d[3*CW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (stat_d == valrot_pkg::STAT_ROTATED) begin
        out_x_r <= y[0];
        out_y_r <= y[1];
        out_z_r <= y[2];
      end else begin
        out_x_r <= v136[0];
        out_y_r <= v136[1];
        out_z_r <= v136[2];
      end
      out_status_r <= stat_d;
    end
  end

  assign out_if.valid = out_valid_r;
  assign out_if.out_x = out_x_r;
  assign out_if.out_y = out_y_r;
  assign out_if.out_z = out_z_r;
  assign out_if.status = out_status_r;

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid_r)
    else $error("output valid not cleared by reset");

  a_valid_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
    en && v2_d[3*CW] |=> out_valid_r)
    else $error("pipeline transaction lost at output register");

  a_out_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_status_r != 2'd3)
    else $error("illegal status on output");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  localparam int N_RANDOM = 950;
  localparam int QUIET_FROM = 800;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 200;

  typedef logic signed [31:0] coord_t;
  typedef longint vec3_t [3];

  typedef struct {
    coord_t fx, fy, fz, tx, ty, tz, vx, vy, vz;
  } rot_req_t;

  typedef struct {
    coord_t x, y, z;
    valrot_pkg::status_t st;
  } rot_res_t;

  typedef struct {
    rot_req_t req;
    bit known;
    rot_res_t res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  valrot_in_if in_if ();
  valrot_out_if out_if ();

  vector_align_rotation DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_if(in_if),
    .out_if(out_if)
  );

  always #10 clk = ~clk;

  rot_res_t rotated_q[$];
  stim_row_t dir_rows[$];
  int mismatches = 0;
  int sent = 0;
  int received = 0;
  int stat_seen [3] = '{0, 0, 0};
  int idle_cycles = 0;
  bit quiet = 1'b0;

  task automatic report(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= r + bitv) begin
        x -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  function automatic longint round_q30(input longint v);
    longint unsigned m;
    m = v < 0 ? longint'(-v) : longint'(v);
    m = (m + (64'd1 << 29)) >> 30;
    return v < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic bit unit_dir(input coord_t cx, input coord_t cy, input coord_t cz,
                                  output vec3_t u);
    longint c [3];
    longint unsigned a [3];
    longint unsigned m, sum, r, q;
    int rs, ls;
    c = '{longint'(cx), longint'(cy), longint'(cz)};
    m = 0;
    sum = 0;
    rs = 0;
    ls = 0;
    u = '{0, 0, 0};
    for (int i = 0; i < 3; i++) begin
      a[i] = c[i] < 0 ? -c[i] : c[i];
      if (a[i] > m) m = a[i];
    end
    if (m == 0) return 1'b0;
    while (m >= (64'd1 << 23)) begin m >>= 1; rs++; end
    while (m < (64'd1 << 22)) begin m <<= 1; ls++; end
    for (int i = 0; i < 3; i++) begin
      a[i] = (a[i] >> rs) << ls;
      sum += a[i] * a[i];
    end
    r = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((a[i] << 30) + (r >> 1)) / r;
      u[i] = c[i] < 0 ? -longint'(q) : longint'(q);
    end
    return 1'b1;
  endfunction

  function automatic coord_t apply_row(input longint r0, input longint r1, input longint r2,
                                       input rot_req_t q);
    logic signed [95:0] acc;
    acc = 96'(r0) * 96'(q.vx) + 96'(r1) * 96'(q.vy) + 96'(r2) * 96'(q.vz);
    acc = (acc + (96'sd1 <<< 29)) >>> 30;
    if (acc > 96'sd2147483647) return 32'h7fffffff;
    if (acc < -96'sd2147483648) return 32'h80000000;
    return coord_t'(acc);
  endfunction

  function automatic rot_res_t rotate_vec(input rot_req_t q);
    rot_res_t o;
    vec3_t f, t, k, n;
    longint one, c, b, p00, p11, p22, p01, p02, p12;
    longint unsigned k2, s, qq;
    longint rm [3][3];
    one = 64'sd1 <<< 30;
    o.x = q.vx;
    o.y = q.vy;
    o.z = q.vz;
    o.st = valrot_pkg::STAT_DEGEN;
    if (!unit_dir(q.fx, q.fy, q.fz, f) || !unit_dir(q.tx, q.ty, q.tz, t)) return o;
    c = round_q30(f[0] * t[0] + f[1] * t[1] + f[2] * t[2]);
    if (c > one) c = one;
    if (c < -one) c = -one;
    k[0] = round_q30(f[1] * t[2] - f[2] * t[1]);
    k[1] = round_q30(f[2] * t[0] - f[0] * t[2]);
    k[2] = round_q30(f[0] * t[1] - f[1] * t[0]);
    k2 = 0;
    for (int i = 0; i < 3; i++) k2 += longint'(k[i] * k[i]);
    if (k2 < 64'd1152922) begin
      o.st = c >= 0 ? valrot_pkg::STAT_ALIGNED : valrot_pkg::STAT_DEGEN;
      return o;
    end
    s = int_sqrt(k2);
    for (int i = 0; i < 3; i++) begin
      qq = (((k[i] < 0 ? -k[i] : k[i]) << 30) + (s >> 1)) / s;
      n[i] = k[i] < 0 ? -longint'(qq) : longint'(qq);
    end
    b = one - c;
    p00 = round_q30(n[0] * n[0]);
    p11 = round_q30(n[1] * n[1]);
    p22 = round_q30(n[2] * n[2]);
    p01 = round_q30(n[0] * n[1]);
    p02 = round_q30(n[0] * n[2]);
    p12 = round_q30(n[1] * n[2]);
    rm[0][0] = one - round_q30(b * (p11 + p22));
    rm[0][1] = -k[2] + round_q30(b * p01);
    rm[0][2] = k[1] + round_q30(b * p02);
    rm[1][0] = k[2] + round_q30(b * p01);
    rm[1][1] = one - round_q30(b * (p22 + p00));
    rm[1][2] = -k[0] + round_q30(b * p12);
    rm[2][0] = -k[1] + round_q30(b * p02);
    rm[2][1] = k[0] + round_q30(b * p12);
    rm[2][2] = one - round_q30(b * (p11 + p00));
    o.x = apply_row(rm[0][0], rm[0][1], rm[0][2], q);
    o.y = apply_row(rm[1][0], rm[1][1], rm[1][2], q);
    o.z = apply_row(rm[2][0], rm[2][1], rm[2][2], q);
    o.st = valrot_pkg::STAT_ROTATED;
    return o;
  endfunction

  function automatic coord_t rnd_signed(input int bits);
    coord_t v;
    v = coord_t'($urandom_range((32'd1 << bits) - 1, 0));
    return $urandom_range(1, 0) ? -v : v;
  endfunction

  function automatic rot_req_t random_req();
    rot_req_t q;
    int kind;
    int sh;
    kind = $urandom_range(9, 0);
    q = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
          $urandom, $urandom, $urandom};
    case (kind)
      3, 4: begin
        sh = $urandom_range(20, 1);
        q.fx = rnd_signed(sh); q.fy = rnd_signed(sh); q.fz = rnd_signed(sh);
        q.tx = rnd_signed(sh); q.ty = rnd_signed(sh); q.tz = rnd_signed(sh);
        q.vx = rnd_signed(20); q.vy = rnd_signed(20); q.vz = rnd_signed(20);
      end
      5: begin
        q.fx = rnd_signed(24); q.fy = rnd_signed(24); q.fz = rnd_signed(24);
        q.tx = q.fx + rnd_signed(2); q.ty = q.fy + rnd_signed(2); q.tz = q.fz + rnd_signed(2);
      end
      6: begin
        q.fx = rnd_signed(24); q.fy = rnd_signed(24); q.fz = rnd_signed(24);
        q.tx = -q.fx + rnd_signed(1); q.ty = -q.fy; q.tz = -q.fz;
      end
      7: begin
        if ($urandom_range(1, 0)) begin
          q.fx = 0; q.fy = 0; q.fz = 0;
        end else begin
          q.tx = 0; q.ty = 0; q.tz = 0;
        end
      end
      8: begin
        q.fy = 0; q.tz = 0;
      end
      default: ;
    endcase
    return q;
  endfunction

  function automatic rot_res_t pass_res(input rot_req_t q, input valrot_pkg::status_t st);
    rot_res_t o;
    o = '{q.vx, q.vy, q.vz, st};
    return o;
  endfunction

  task automatic add_row(input rot_req_t q, input bit known, input valrot_pkg::status_t st);
    stim_row_t r;
    r.req = q;
    r.known = known;
    r.res = pass_res(q, st);
    dir_rows = {dir_rows, r};
  endtask

  task automatic send_req(input rot_req_t q);
    if (!quiet && $urandom_range(3, 0) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(18, 1)) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    {in_if.from_x, in_if.from_y, in_if.from_z} <= {q.fx, q.fy, q.fz};
    {in_if.to_x, in_if.to_y, in_if.to_z} <= {q.tx, q.ty, q.tz};
    {in_if.vec_x, in_if.vec_y, in_if.vec_z} <= {q.vx, q.vy, q.vz};
    do @(posedge clk); while (!in_if.ready);
  endtask

  // scoreboard: predict on input transaction, compare on output transaction
  always @(posedge clk) begin
    rot_req_t q;
    rot_res_t e;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        q = '{in_if.from_x, in_if.from_y, in_if.from_z, in_if.to_x, in_if.to_y,
              in_if.to_z, in_if.vec_x, in_if.vec_y, in_if.vec_z};
        rotated_q = {rotated_q, rotate_vec(q)};
      end
      if (out_if.valid && out_if.ready) begin
        received++;
        if (rotated_q.size() == 0) begin
          report("output transaction with nothing expected");
        end else begin
          e = rotated_q.pop_front();
          if (out_if.status <= 2) stat_seen[out_if.status]++;
          if (out_if.out_x !== e.x || out_if.out_y !== e.y || out_if.out_z !== e.z ||
              out_if.status !== e.st)
            report($sformatf("got (%h %h %h st%0d) exp (%h %h %h st%0d)",
                             out_if.out_x, out_if.out_y, out_if.out_z, out_if.status,
                             e.x, e.y, e.z, e.st));
        end
      end
    end
  end

  // directed rows with a typed-in result: check the predictor itself
  task automatic check_rows();
    rot_res_t p;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].known) begin
        p = rotate_vec(dir_rows[i].req);
        if (p.x !== dir_rows[i].res.x || p.y !== dir_rows[i].res.y ||
            p.z !== dir_rows[i].res.z || p.st !== dir_rows[i].res.st)
          report($sformatf("directed row %0d: predictor disagrees", i));
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", idle_cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    out_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      out_if.ready <= 1'b1;
      repeat ($urandom_range(40, 1)) @(posedge clk);
      if (!quiet) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(18, 1)) @(posedge clk);
      end
    end
  end

  initial begin
    coord_t mx, mn;
    mx = 32'h7fffffff;
    mn = 32'h80000000;
    in_if.valid = 1'b0;
    {in_if.from_x, in_if.from_y, in_if.from_z} = '0;
    {in_if.to_x, in_if.to_y, in_if.to_z} = '0;
    {in_if.vec_x, in_if.vec_y, in_if.vec_z} = '0;

    add_row('{0, 0, 0, 65536, 0, 0, 1, 2, 3}, 1, valrot_pkg::STAT_DEGEN);
    add_row('{65536, 0, 0, 0, 0, 0, mx, mn, -1}, 1, valrot_pkg::STAT_DEGEN);
    add_row('{0, 0, 0, 0, 0, 0, mn, mx, 0}, 1, valrot_pkg::STAT_DEGEN);
    add_row('{65536, 0, 0, 65536, 0, 0, mx, mn, mx}, 1, valrot_pkg::STAT_ALIGNED);
    add_row('{mx, mx, mx, 1, 1, 1, mn, mn, mn}, 1, valrot_pkg::STAT_ALIGNED);
    add_row('{mn, 0, 0, mx, 0, 0, 5, -7, 9}, 1, valrot_pkg::STAT_DEGEN);
    add_row('{0, 65536, 0, 0, -3, 0, mx, 0, mn}, 1, valrot_pkg::STAT_DEGEN);
    add_row('{1, 0, 0, 0, 1, 0, 65536, 0, 0}, 0, valrot_pkg::STAT_ROTATED);
    add_row('{65536, 0, 0, 0, 0, 65536, mx, mx, mx}, 0, valrot_pkg::STAT_ROTATED);
    add_row('{mx, 0, 0, 0, mn, 0, mn, mn, mn}, 0, valrot_pkg::STAT_ROTATED);
    add_row('{mn, mn, mn, mx, 0, mn, mx, mn, mx}, 0, valrot_pkg::STAT_ROTATED);
    add_row('{1, 1, 0, -1, 1, 0, mx, mx, 0}, 0, valrot_pkg::STAT_ROTATED);
    add_row('{mx, mx, mx, mn, mx, mx, mx, mx, mx}, 0, valrot_pkg::STAT_ROTATED);
    add_row('{1, 0, 0, -1, 1, 0, 0, 0, 65536}, 0, valrot_pkg::STAT_ROTATED);
    add_row('{-1, -1, -1, 1, -1, 1, -1, -1, -1}, 0, valrot_pkg::STAT_ROTATED);
    add_row('{65536, 1, 0, 65536, 0, 0, 100, 200, 300}, 0, valrot_pkg::STAT_ROTATED);
    add_row('{0, 0, 65536, 0, 0, 65535, 1, 1, 1}, 0, valrot_pkg::STAT_ROTATED);
    check_rows();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_req(dir_rows[i].req);
      sent++;
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == QUIET_FROM) quiet = 1'b1;
      send_req(random_req());
      sent++;
    end
    in_if.valid <= 1'b0;

    while (rotated_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d input transactions sent, %0d results checked", sent, received);
    $display("rotated %0d, aligned %0d, degenerate %0d; %0d mismatches",
             stat_seen[0], stat_seen[1], stat_seen[2], mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/valrot_pkg.sv
src/valrot_if.sv
src/valrot_delay.sv
src/valrot_isqrt.sv
src/valrot_div.sv
src/valrot_unit.sv
src/valrot_apply.sv
src/vector_align_rotation.sv
bench/testbench.sv
